>>> design/vrtr_pkg.sv
package vrtr_pkg;

  localparam int BUF_BYTES = 4096;
  localparam int MSG_MAX   = 255;
  localparam int HDR_BYTES = 10;
  localparam int REC_MAX   = 272;
  localparam int AW        = $clog2(BUF_BYTES);
  localparam int SAW       = $clog2(MSG_MAX);
  localparam int OFS_W     = $clog2(BUF_BYTES + 3 * REC_MAX + 1);
  localparam logic [7:0] STG_MAX = 8'(MSG_MAX - 1);

  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_WALK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] entry_time;
    logic [7:0]  entry_type;
    logic [7:0]  msg_byte;
    logic        msg_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [63:0] out_time;
    logic [7:0]  out_type;
    logic        record_end;
    logic        walk_done;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_PL_INIT, OP_RD_NLEN, OP_SET_OFF, OP_WRAP, OP_OFF0, OP_ZERO,
    OP_RD_OLEN, OP_ADV_OLD, OP_NR, OP_NR_FAIL, OP_HDR, OP_CP, OP_NUL,
    OP_WRD, OP_WOUT, OP_WDONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic acc;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic wfin;
    logic fits;
    logic wrap_reset;
    logic wrapped;
    logic zero_ok;
    logic evict_more;
    logic nr_short;
    logic nz;
    logic cnt9;
    logic cnt10;
    logic cp_end;
    logic walk_more;
    logic mode_walk;
  } status_t;

  function automatic logic [8:0] pad_size(input logic [7:0] len);
    logic [9:0] s;
    s = 10'(HDR_BYTES) + 10'(len) + 10'd7;
    return s[8:0] & 9'h1F8;
  endfunction

endpackage

>>> design/variable_record_trace_ring.sv
// Append byte: staged while the block stays idle. Last byte: evicts old records as
// needed, then writes header, message and terminator one byte at a time through the
// single write port of the record RAM. Walk step: reads the header and one message byte,
// then after a record's end probes the next; the result strobe is registered, ahead of the probe.
// One item at a time; busy is high while an item is in work. The receiver cannot stall.
// Reset clears control state only; the record and staging RAMs need no clearing pass.
module variable_record_trace_ring import vrtr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  cmd_t    cmd;
  status_t st;

  vrtr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_item.mode),
    .in_last (in_item.msg_last),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy)
  );

  vrtr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> design/vrtr_ram.sv
module vrtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/vrtr_ctrl.sv
module vrtr_ctrl import vrtr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  logic       in_last,
  input  status_t    st,
  output cmd_t       cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_IDLE, S_PCHK, S_PLEN, S_PDEC, S_ZERO, S_EV, S_ELEN, S_NR0, S_NR, S_NRC,
    S_HDR, S_CP, S_NUL, S_WCHK, S_WRD, S_WOUT
  } state_t;

  state_t state_r, state_nxt;
  op_t    op;

  assign busy    = (state_r != S_IDLE);
  assign cmd.acc = start && (state_r == S_IDLE);
  assign cmd.op  = op;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_mode == MODE_APPEND && in_last) state_nxt = S_PCHK;
          else if (in_mode == MODE_WALK) state_nxt = S_WCHK;
        end
      end
      S_PCHK: begin
        if (st.empty) begin
          op = OP_PL_INIT;
          state_nxt = S_HDR;
        end else begin
          op = OP_RD_NLEN;
          state_nxt = S_PLEN;
        end
      end
      S_PLEN: begin
        op = OP_SET_OFF;
        state_nxt = S_PDEC;
      end
      S_PDEC: begin
        priority if (st.fits) begin
          state_nxt = S_HDR;
        end else if (st.wrap_reset) begin
          op = OP_WRAP;
          state_nxt = S_HDR;
        end else if (!st.wrapped && st.zero_ok) begin
          state_nxt = S_ZERO;
        end else if (!st.wrapped) begin
          op = OP_OFF0;
          state_nxt = S_EV;
        end else begin
          state_nxt = S_EV;
        end
      end
      S_ZERO: begin
        op = OP_ZERO;
        if (st.cnt9) state_nxt = S_EV;
      end
      S_EV: begin
        if (st.evict_more) begin
          op = OP_RD_OLEN;
          state_nxt = S_ELEN;
        end else begin
          state_nxt = S_HDR;
        end
      end
      S_ELEN: begin
        op = OP_ADV_OLD;
        state_nxt = S_NR0;
      end
      S_NR0: begin
        if (st.nr_short) begin
          op = OP_NR_FAIL;
          state_nxt = st.mode_walk ? S_IDLE : S_HDR;
        end else begin
          state_nxt = S_NR;
        end
      end
      S_NR: begin
        op = OP_NR;
        if (st.cnt10) state_nxt = S_NRC;
      end
      S_NRC: begin
        if (!st.nz) begin
          op = OP_NR_FAIL;
          state_nxt = st.mode_walk ? S_IDLE : S_HDR;
        end else begin
          state_nxt = st.mode_walk ? S_IDLE : S_EV;
        end
      end
      S_HDR: begin
        op = OP_HDR;
        if (st.cnt9) state_nxt = S_CP;
      end
      S_CP: begin
        op = OP_CP;
        if (st.cp_end) state_nxt = S_NUL;
      end
      S_NUL: begin
        op = OP_NUL;
        state_nxt = S_IDLE;
      end
      S_WCHK: begin
        if (st.empty || st.wfin) begin
          op = OP_WDONE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        op = OP_WRD;
        if (st.cnt10) state_nxt = S_WOUT;
      end
      S_WOUT: begin
        op = OP_WOUT;
        state_nxt = st.walk_more ? S_NR0 : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/vrtr_dp.sv
module vrtr_dp import vrtr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output status_t   st,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [OFS_W-1:0] BUF_O = OFS_W'(BUF_BYTES);
  localparam logic [OFS_W-1:0] HDR_O = OFS_W'(HDR_BYTES);

  in_item_t         item_r;
  logic [7:0]       stg_cnt_r, cnt_r, widx_r, wtype_r, wlen_r;
  logic [OFS_W-1:0] oldest_r, newest_r, off_r, walk_r;
  logic             wfin_r, nz_r, zf_r, out_valid_r;
  logic [63:0]      wtime_r;
  out_item_t        out_r;

  logic [OFS_W-1:0] wa, ra, size, end_o, nr_ptr, limit;
  logic             we;
  logic [7:0]       wd, ram_q, stg_q, rdata, hdr_byte, wlast;
  logic             stg_we, counting, empty, wrapped;
  logic [3:0]       k;

  assign rdata   = zf_r ? 8'd0 : ram_q;
  assign size    = OFS_W'(pad_size(stg_cnt_r + 8'd1));
  assign end_o   = off_r + size;
  assign empty   = (oldest_r >= BUF_O);
  assign wrapped = (newest_r < oldest_r);
  assign limit   = wrapped ? oldest_r : BUF_O;
  assign nr_ptr  = (item_r.mode == MODE_WALK) ? walk_r : oldest_r;
  assign wlast   = (wlen_r >= 8'd2) ? wlen_r - 8'd2 : 8'd0;
  assign k       = 4'(cnt_r - 8'd1);

  always_comb begin
    st.empty      = empty;
    st.wfin       = wfin_r;
    st.fits       = (end_o <= limit);
    st.wrap_reset = wrapped && (end_o > BUF_O);
    st.wrapped    = wrapped;
    st.zero_ok    = (off_r + HDR_O <= BUF_O);
    st.evict_more = (end_o > oldest_r);
    st.nr_short   = (nr_ptr + HDR_O > BUF_O);
    st.nz         = nz_r;
    st.cnt9       = (cnt_r == 8'd9);
    st.cnt10      = (cnt_r == 8'd10);
    st.cp_end     = (cnt_r == stg_cnt_r);
    st.walk_more  = (widx_r >= wlast) && (walk_r != newest_r);
    st.mode_walk  = (item_r.mode == MODE_WALK);
  end

  always_comb begin
    unique case (cnt_r[3:0])
      4'd8:    hdr_byte = item_r.entry_type;
      4'd9:    hdr_byte = stg_cnt_r + 8'd1;
      default: hdr_byte = item_r.entry_time[{cnt_r[2:0], 3'b000} +: 8];
    endcase
  end

  always_comb begin
    wa = off_r + OFS_W'(cnt_r);
    wd = 8'd0;
    we = 1'b0;
    ra = newest_r + OFS_W'(9);
    unique case (cmd.op)
      OP_ZERO: we = 1'b1;
      OP_HDR: begin
        we = 1'b1;
        wd = hdr_byte;
      end
      OP_CP: begin
        we = (cnt_r != 8'd0);
        wa = off_r + HDR_O + OFS_W'(cnt_r) - OFS_W'(1);
        wd = stg_q;
      end
      OP_NUL: begin
        we = 1'b1;
        wa = off_r + HDR_O + OFS_W'(stg_cnt_r);
      end
      OP_RD_OLEN: ra = oldest_r + OFS_W'(9);
      OP_NR:      ra = nr_ptr + OFS_W'(cnt_r);
      OP_WRD: begin
        ra = (cnt_r < 8'd10) ? walk_r + OFS_W'(cnt_r)
                             : walk_r + HDR_O + OFS_W'(widx_r);
      end
      default: ;
    endcase
  end

  assign stg_we = cmd.acc && (in_item.mode == MODE_APPEND) && (stg_cnt_r < STG_MAX);

  vrtr_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_store (
    .clk   (clk),
    .we    (we && (wa < BUF_O)),
    .waddr (wa[AW-1:0]),
    .wdata (wd),
    .raddr (ra[AW-1:0]),
    .rdata (ram_q)
  );

  vrtr_ram #(.WIDTH(8), .DEPTH(MSG_MAX)) u_stage (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_cnt_r[SAW-1:0]),
    .wdata (in_item.msg_byte),
    .raddr (cnt_r[SAW-1:0]),
    .rdata (stg_q)
  );

  assign counting = (cmd.op == OP_ZERO) || (cmd.op == OP_NR) || (cmd.op == OP_HDR)
                 || (cmd.op == OP_CP) || (cmd.op == OP_WRD);

  // payload and scratch registers
  always_ff @(posedge clk) begin
    zf_r <= (ra >= BUF_O);
    if (cmd.acc) item_r <= in_item;
    if (!counting) begin
      cnt_r <= 8'd0;
      nz_r  <= 1'b0;
    end else if (cmd.op == OP_HDR && cnt_r == 8'd9) begin
      cnt_r <= 8'd0;
    end else begin
      cnt_r <= cnt_r + 8'd1;
    end
    if (cmd.op == OP_NR && cnt_r != 8'd0 && rdata != 8'd0) nz_r <= 1'b1;
    unique case (cmd.op)
      OP_PL_INIT, OP_WRAP, OP_OFF0: off_r <= '0;
      OP_SET_OFF: off_r <= newest_r + OFS_W'(pad_size(rdata));
      OP_ZERO:    if (cnt_r == 8'd9) off_r <= '0;
      default: ;
    endcase
    if (cmd.op == OP_WRD && cnt_r != 8'd0) begin
      unique case (k)
        4'd8:    wtype_r <= rdata;
        4'd9:    wlen_r  <= rdata;
        default: wtime_r[{k[2:0], 3'b000} +: 8] <= rdata;
      endcase
    end
    if (cmd.op == OP_WDONE) begin
      out_r <= '{out_byte: 8'd0, out_time: 64'd0, out_type: 8'd0,
                 record_end: 1'b0, walk_done: 1'b1};
    end else if (cmd.op == OP_WOUT) begin
      out_r <= '{out_byte: rdata, out_time: wtime_r, out_type: wtype_r,
                 record_end: (widx_r >= wlast), walk_done: 1'b0};
    end else begin
      out_r <= '0;
    end
  end

  // ring control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_cnt_r   <= 8'd0;
      oldest_r    <= BUF_O;
      newest_r    <= BUF_O;
      walk_r      <= '0;
      widx_r      <= 8'd0;
      wfin_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_WOUT) || (cmd.op == OP_WDONE);
      if (stg_we) stg_cnt_r <= stg_cnt_r + 8'd1;
      if (cmd.acc && in_item.mode == MODE_RESTART) begin
        walk_r <= empty ? '0 : oldest_r;
        widx_r <= 8'd0;
        wfin_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_PL_INIT, OP_WRAP: oldest_r <= '0;
        OP_ADV_OLD: oldest_r <= oldest_r + OFS_W'(pad_size(rdata));
        OP_NR_FAIL: begin
          if (item_r.mode == MODE_WALK) walk_r <= '0;
          else oldest_r <= '0;
        end
        OP_NUL: begin
          newest_r  <= off_r;
          stg_cnt_r <= 8'd0;
        end
        OP_WOUT: begin
          if (widx_r >= wlast) begin
            widx_r <= 8'd0;
            if (walk_r == newest_r) wfin_r <= 1'b1;
            else walk_r <= walk_r + OFS_W'(pad_size(wlen_r));
          end else begin
            widx_r <= widx_r + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import vrtr_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  variable_record_trace_ring u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // shadow of the trace ring
  logic [7:0] ring_mem [BUF_BYTES];
  bit         ring_written [BUF_BYTES];
  logic [7:0] stage_mem [MSG_MAX];
  int         stage_cnt;
  int         oldest_ofs;
  int         newest_ofs;
  int         walk_ofs;
  int         walk_idx;
  bit         walk_fin;

  out_item_t  walk_results_q[$];
  int         errors;
  int         items_sent;
  int         records_placed;
  int         results_seen;
  int         done_seen;
  int         sender_idle_pct;

  function automatic logic [7:0] ring_rd(input int o);
    return (o < BUF_BYTES) ? ring_mem[o] : 8'h00;
  endfunction

  function automatic void ring_put(input int o, input logic [7:0] v);
    if (o < BUF_BYTES) begin
      ring_mem[o]     = v;
      ring_written[o] = 1'b1;
    end
  endfunction

  function automatic int rec_size(input int len);
    return (HDR_BYTES + len + 7) & ~7;
  endfunction

  function automatic int size_at(input int o);
    return rec_size(ring_rd(o + 9));
  endfunction

  function automatic bit no_header_at(input int o);
    if (o + HDR_BYTES > BUF_BYTES) return 1'b1;
    for (int i = 0; i < HDR_BYTES; i++)
      if (ring_rd(o + i) != 8'h00) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void place_record(input logic [63:0] tstamp, input logic [7:0] rtype);
    int  len;
    int  sz;
    int  ofs;
    int  lim;
    bit  wrapped;
    len = stage_cnt + 1;
    sz  = rec_size(len);
    if (oldest_ofs >= BUF_BYTES) begin
      oldest_ofs = 0;
      ofs        = 0;
    end else begin
      ofs     = newest_ofs + size_at(newest_ofs);
      wrapped = newest_ofs < oldest_ofs;
      lim     = wrapped ? oldest_ofs : BUF_BYTES;
      if (ofs + sz > lim) begin
        if (wrapped && ofs + sz > BUF_BYTES) begin
          oldest_ofs = 0;
          ofs        = 0;
        end else begin
          if (!wrapped) begin
            // zero dummy header marks the wrap point
            if (ofs + HDR_BYTES <= BUF_BYTES)
              for (int i = 0; i < HDR_BYTES; i++) ring_put(ofs + i, 8'h00);
            ofs = 0;
          end
          while (ofs + sz > oldest_ofs) begin
            oldest_ofs += size_at(oldest_ofs);
            if (no_header_at(oldest_ofs)) begin
              oldest_ofs = 0;
              break;
            end
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) ring_put(ofs + i, tstamp[8*i +: 8]);
    ring_put(ofs + 8, rtype);
    ring_put(ofs + 9, 8'(len));
    for (int i = 0; i + 1 < len; i++) ring_put(ofs + HDR_BYTES + i, stage_mem[i]);
    ring_put(ofs + HDR_BYTES + len - 1, 8'h00);
    newest_ofs = ofs;
    records_placed++;
  endfunction

  function automatic bit byte_ok(input int o);
    return (o >= BUF_BYTES) || ring_written[o];
  endfunction

  // a walk step must never touch storage that was never written
  function automatic bit walk_step_safe();
    int len;
    int last;
    int nxt;
    if (oldest_ofs >= BUF_BYTES || walk_fin) return 1'b1;
    for (int i = 0; i < HDR_BYTES; i++)
      if (!byte_ok(walk_ofs + i)) return 1'b0;
    len  = ring_rd(walk_ofs + 9);
    last = (len >= 2) ? len - 2 : 0;
    if (!byte_ok(walk_ofs + HDR_BYTES + walk_idx)) return 1'b0;
    if (walk_idx >= last && walk_ofs != newest_ofs) begin
      nxt = walk_ofs + rec_size(len);
      if (nxt + HDR_BYTES <= BUF_BYTES)
        for (int i = 0; i < HDR_BYTES; i++)
          if (!byte_ok(nxt + i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_trace(input in_item_t it);
    out_item_t r;
    int        len;
    int        last;
    case (it.mode)
      MODE_APPEND: begin
        if (stage_cnt < MSG_MAX - 1) begin
          stage_mem[stage_cnt] = it.msg_byte;
          stage_cnt++;
        end
        if (it.msg_last) begin
          place_record(it.entry_time, it.entry_type);
          stage_cnt = 0;
        end
      end
      MODE_RESTART: begin
        walk_ofs = (oldest_ofs >= BUF_BYTES) ? 0 : oldest_ofs;
        walk_idx = 0;
        walk_fin = 1'b0;
      end
      MODE_WALK: begin
        r = '0;
        if (oldest_ofs >= BUF_BYTES || walk_fin) begin
          r.walk_done = 1'b1;
        end else begin
          for (int i = 0; i < 8; i++) r.out_time[8*i +: 8] = ring_rd(walk_ofs + i);
          len        = ring_rd(walk_ofs + 9);
          last       = (len >= 2) ? len - 2 : 0;
          r.out_byte = ring_rd(walk_ofs + HDR_BYTES + walk_idx);
          r.out_type = ring_rd(walk_ofs + 8);
          if (walk_idx >= last) begin
            r.record_end = 1'b1;
            walk_idx     = 0;
            if (walk_ofs == newest_ofs) begin
              walk_fin = 1'b1;
            end else begin
              walk_ofs += rec_size(len);
              if (no_header_at(walk_ofs)) walk_ofs = 0;
            end
          end else begin
            walk_idx++;
          end
        end
        walk_results_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (walk_results_q.size() == 0) begin
        report_mismatch("unexpected walk result", 64'(out_item.out_byte), 64'd0);
      end else begin
        want = walk_results_q.pop_front();
        if (want.walk_done) done_seen++;
        if (out_item.out_byte !== want.out_byte)
          report_mismatch("out_byte", 64'(out_item.out_byte), 64'(want.out_byte));
        if (out_item.out_time !== want.out_time)
          report_mismatch("out_time", out_item.out_time, want.out_time);
        if (out_item.out_type !== want.out_type)
          report_mismatch("out_type", 64'(out_item.out_type), 64'(want.out_type));
        if (out_item.record_end !== want.record_end)
          report_mismatch("record_end", 64'(out_item.record_end), 64'(want.record_end));
        if (out_item.walk_done !== want.walk_done)
          report_mismatch("walk_done", 64'(out_item.walk_done), 64'(want.walk_done));
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input in_item_t it);
    if (it.mode == MODE_WALK && !walk_step_safe()) it.mode = MODE_RESTART;
    start   = 1'b1;
    in_item = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_trace(it);
    items_sent++;
    @(negedge clk);
    start = 1'b0;
    if ($urandom_range(99) < sender_idle_pct)
      repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  function automatic in_item_t rand_item(input logic [1:0] mode);
    in_item_t it;
    it.mode       = mode;
    it.entry_time = {$urandom, $urandom};
    it.entry_type = 8'($urandom);
    it.msg_byte   = 8'($urandom);
    it.msg_last   = 1'b0;
    return it;
  endfunction

  task automatic append_record(input int len, input logic [63:0] tstamp,
                               input logic [7:0] rtype);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it = rand_item(MODE_APPEND);
      if ($urandom_range(19) == 0) it.msg_byte = 8'h00;
      if (i == len - 1) begin
        it.msg_last   = 1'b1;
        it.entry_time = tstamp;
        it.entry_type = rtype;
      end
      send_item(it);
    end
  endtask

  task automatic walk_steps(input int n);
    for (int i = 0; i < n; i++) send_item(rand_item(MODE_WALK));
  endtask

  task automatic settle();
    while (walk_results_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    in_item_t it;
    sender_idle_pct = 0;
    walk_steps(2);                                  // empty ring
    send_item(rand_item(MODE_UNUSED));
    send_item(rand_item(MODE_RESTART));
    walk_steps(1);
    it = rand_item(MODE_APPEND);
    it.msg_byte = 8'h00;
    send_item(it);
    it.msg_byte = 8'hFF;
    it.msg_last = 1'b1;
    it.entry_time = '1;
    it.entry_type = 8'hFF;
    send_item(it);
    append_record(1, 64'h0, 8'h00);                 // one message byte plus terminator
    append_record(3, 64'h0123_4567_89AB_CDEF, 8'h01);
    walk_steps(3);                                  // walk from offset 0, no restart
    send_item(rand_item(MODE_RESTART));
    walk_steps(7);
    settle();
  endtask

  task automatic test_random(input int pct, input int n_items);
    int        stop_at;
    int        len;
    int        k;
    logic [63:0] ts;
    sender_idle_pct = pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      k = $urandom_range(99);
      if (k < 70)      len = $urandom_range(1, 12);
      else if (k < 88) len = $urandom_range(13, 80);
      else             len = $urandom_range(240, 300);   // includes truncation
      k  = $urandom_range(9);
      ts = (k == 0) ? 64'h0 : (k == 1) ? '1 : {$urandom, $urandom};
      append_record(len, ts, (k == 2) ? 8'h00 : 8'($urandom_range(1, 255)));
      k = $urandom_range(99);
      if (k < 40) begin
        if ($urandom_range(3) != 0) send_item(rand_item(MODE_RESTART));
        walk_steps($urandom_range(1, 40));
      end else if (k < 45) begin
        send_item(rand_item(MODE_UNUSED));
      end
    end
    settle();
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    errors    = 0;
    stage_cnt = 0;
    oldest_ofs = BUF_BYTES;
    newest_ofs = BUF_BYTES;
    walk_ofs  = 0;
    walk_idx  = 0;
    walk_fin  = 1'b0;
    for (int i = 0; i < BUF_BYTES; i++) begin
      ring_mem[i]     = 8'h00;
      ring_written[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(0, 200);
    test_random(53, 200);
    test_random(0, 200);
    test_random(35, 200);

    $display("Sent %0d items, placed %0d records, checked %0d walk results (%0d walk_done).",
             items_sent, records_placed, results_seen, done_seen);
    if (errors == 0) begin
      $display("variable_record_trace_ring: match");
    end else begin
      $display("variable_record_trace_ring: mismatch");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timeout with %0d walk results outstanding", walk_results_q.size());
    $display("variable_record_trace_ring: mismatch");
    $finish;
  end

endmodule
